>>> src/ffc_pkg.sv
`default_nettype none

package ffc_pkg;

    localparam logic [7:0] KEY_ESC   = 8'd27;
    localparam logic [7:0] KEY_CR    = 8'h0D;
    localparam logic [7:0] KEY_LF    = 8'h0A;
    localparam logic [7:0] KEY_EQ    = 8'h3D;
    localparam logic [7:0] KEY_PLUS  = 8'h2B;
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_STAR  = 8'h2A;
    localparam logic [7:0] KEY_SLASH = 8'h2F;
    localparam logic [7:0] KEY_LC_C  = 8'h63;
    localparam logic [7:0] KEY_UC_C  = 8'h43;
    localparam logic [7:0] KEY_D0    = 8'h30;
    localparam logic [7:0] KEY_D9    = 8'h39;

    localparam logic [31:0] INT_MIN_BITS = 32'h8000_0000;
    localparam logic [35:0] ENTRY_MAX    = 36'd2147483647;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KC_NONE  = 2'd0,
        KC_CLEAR = 2'd1,
        KC_OP    = 2'd2,
        KC_DIGIT = 2'd3
    } key_class_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECODE = 3'd1,
        ST_ITER   = 3'd2,
        ST_FIN    = 3'd3,
        ST_RESULT = 3'd4
    } state_t;

    typedef struct packed {
        logic load_key;
        logic apply;
        logic start_iter;
        logic step;
        logic finish_iter;
        logic capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_iter;
        logic iter_last;
    } dp_status_t;

    function automatic key_class_t key_class(input logic [7:0] k);
        key_class_t c;
        c = KC_NONE;
        unique case (k) inside
            KEY_ESC, KEY_LC_C, KEY_UC_C:
                c = KC_CLEAR;
            KEY_CR, KEY_LF, KEY_EQ, KEY_PLUS, KEY_MINUS, KEY_STAR, KEY_SLASH:
                c = KC_OP;
            [KEY_D0:KEY_D9]:
                c = KC_DIGIT;
            default:
                c = KC_NONE;
        endcase
        return c;
    endfunction

    function automatic op_t key_op(input logic [7:0] k);
        op_t o;
        o = OP_NONE;
        unique case (k)
            KEY_PLUS:  o = OP_ADD;
            KEY_MINUS: o = OP_SUB;
            KEY_STAR:  o = OP_MUL;
            KEY_SLASH: o = OP_DIV;
            default:   o = OP_NONE;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

>>> src/ffc_ctrl.sv
`default_nettype none

module ffc_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  key_valid,
    output logic                       key_stall,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    input  wire ffc_pkg::dp_status_t   status,
    output ffc_pkg::ctrl_cmd_t         cmd
);

    ffc_pkg::state_t state_reg;
    ffc_pkg::state_t state_next;
    logic            res_valid_reg;
    logic            res_valid_next;
    logic            out_free;

    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffc_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffc_pkg::ST_IDLE:
            begin
                if (key_valid)
                    state_next = ffc_pkg::ST_DECODE;
            end
            ffc_pkg::ST_DECODE:
            begin
                if (status.need_iter)
                    state_next = ffc_pkg::ST_ITER;
                else
                    state_next = ffc_pkg::ST_RESULT;
            end
            ffc_pkg::ST_ITER:
            begin
                if (status.iter_last)
                    state_next = ffc_pkg::ST_FIN;
            end
            ffc_pkg::ST_FIN:
                state_next = ffc_pkg::ST_RESULT;
            ffc_pkg::ST_RESULT:
            begin
                if (out_free)
                    state_next = ffc_pkg::ST_IDLE;
            end
            default:
                state_next = ffc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ffc_pkg::ST_IDLE:
                cmd.load_key = key_valid;
            ffc_pkg::ST_DECODE:
            begin
                cmd.start_iter = status.need_iter;
                cmd.apply      = !status.need_iter;
            end
            ffc_pkg::ST_ITER:
                cmd.step = 1'b1;
            ffc_pkg::ST_FIN:
                cmd.finish_iter = 1'b1;
            ffc_pkg::ST_RESULT:
                cmd.capture = out_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.capture)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    assign key_stall = (state_reg != ffc_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

>>> src/ffc_dp.sv
`default_nettype none

module ffc_dp
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            key_code,
    input  wire ffc_pkg::ctrl_cmd_t    cmd,
    output ffc_pkg::dp_status_t        status,
    output logic signed [31:0]         shown_value,
    output logic                       key_accepted,
    output logic                       shows_result
);

    logic [7:0]           key_reg;
    logic [31:0]          acc_reg;
    logic [31:0]          acc_next;
    logic [31:0]          disp_reg;
    logic [31:0]          disp_next;
    ffc_pkg::op_t         op_reg;
    ffc_pkg::op_t         op_next;
    logic                 fresh_reg;
    logic                 fresh_next;
    logic                 frozen_reg;
    logic                 frozen_next;
    logic                 accepted_reg;
    logic                 accepted_next;

    // shared iterative unit: x = multiplicand / quotient, y = multiplier / divisor,
    // z = product / remainder
    logic [31:0]          x_reg;
    logic [31:0]          x_next;
    logic [31:0]          y_reg;
    logic [31:0]          y_next;
    logic [31:0]          z_reg;
    logic [31:0]          z_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [4:0]           cnt_reg;
    logic [4:0]           cnt_next;

    logic [31:0]          out_value_reg;
    logic                 out_accepted_reg;
    logic                 out_fresh_reg;

    ffc_pkg::key_class_t  cls;
    ffc_pkg::op_t         kop;
    logic [31:0]          operand;
    logic [31:0]          digit;
    logic [35:0]          disp_ext;
    logic [35:0]          entry_sum;
    logic                 entry_ovf;
    logic [31:0]          simple_a;
    logic [31:0]          fin_a;
    logic [31:0]          rem_sh;
    logic [32:0]          rem_diff;
    logic                 is_mul;

    assign cls       = ffc_pkg::key_class(key_reg);
    assign kop       = ffc_pkg::key_op(key_reg);
    assign operand   = (disp_reg == ffc_pkg::INT_MIN_BITS) ? 32'd0 : disp_reg;
    assign digit     = {28'd0, key_reg[3:0]};
    assign disp_ext  = {4'd0, disp_reg};
    assign entry_sum = (disp_ext << 3) + (disp_ext << 1) + {32'd0, key_reg[3:0]};
    assign entry_ovf = (entry_sum > ffc_pkg::ENTRY_MAX);
    assign is_mul    = (op_reg == ffc_pkg::OP_MUL);

    assign rem_sh    = {z_reg[30:0], x_reg[31]};
    assign rem_diff  = {1'b0, rem_sh} - {1'b0, y_reg};

    assign fin_a     = is_mul ? z_reg : (neg_reg ? (32'd0 - x_reg) : x_reg);

    always_comb
    begin
        case (op_reg)
            ffc_pkg::OP_ADD: simple_a = acc_reg + operand;
            ffc_pkg::OP_SUB: simple_a = acc_reg - operand;
            ffc_pkg::OP_DIV: simple_a = acc_reg;
            ffc_pkg::OP_MUL: simple_a = acc_reg;
            default:         simple_a = operand;
        endcase
    end

    assign status.need_iter = (cls == ffc_pkg::KC_OP) &&
                              (is_mul || (op_reg == ffc_pkg::OP_DIV && operand != 32'd0));
    assign status.iter_last = (cnt_reg == 5'd31);

    always_comb
    begin
        acc_next      = acc_reg;
        disp_next     = disp_reg;
        op_next       = op_reg;
        fresh_next    = fresh_reg;
        frozen_next   = frozen_reg;
        accepted_next = accepted_reg;

        if (cmd.apply)
        begin
            accepted_next = 1'b1;
            unique case (cls)
                ffc_pkg::KC_CLEAR:
                begin
                    acc_next    = 32'd0;
                    disp_next   = 32'd0;
                    op_next     = ffc_pkg::OP_NONE;
                    fresh_next  = 1'b1;
                    frozen_next = 1'b0;
                end
                ffc_pkg::KC_OP:
                begin
                    acc_next    = simple_a;
                    disp_next   = simple_a;
                    op_next     = kop;
                    fresh_next  = 1'b1;
                    frozen_next = 1'b0;
                end
                ffc_pkg::KC_DIGIT:
                begin
                    if (fresh_reg)
                    begin
                        disp_next   = digit;
                        fresh_next  = 1'b0;
                        frozen_next = 1'b0;
                    end
                    else if (!frozen_reg)
                    begin
                        if (entry_ovf)
                            frozen_next = 1'b1;
                        else
                            disp_next = entry_sum[31:0];
                    end
                end
                default:
                    accepted_next = 1'b0;
            endcase
        end
        else if (cmd.start_iter)
        begin
            accepted_next = 1'b1;
        end
        else if (cmd.finish_iter)
        begin
            acc_next    = fin_a;
            disp_next   = fin_a;
            op_next     = kop;
            fresh_next  = 1'b1;
            frozen_next = 1'b0;
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        if (cmd.start_iter)
        begin
            cnt_next = 5'd0;
            z_next   = 32'd0;
            neg_next = acc_reg[31] ^ operand[31];
            if (is_mul)
            begin
                x_next = acc_reg;
                y_next = operand;
            end
            else
            begin
                x_next = acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
                y_next = operand[31] ? (32'd0 - operand) : operand;
            end
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (is_mul)
            begin
                z_next = z_reg + (y_reg[0] ? x_reg : 32'd0);
                x_next = {x_reg[30:0], 1'b0};
                y_next = {1'b0, y_reg[31:1]};
            end
            else
            begin
                z_next = rem_diff[32] ? rem_sh : rem_diff[31:0];
                x_next = {x_reg[30:0], !rem_diff[32]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= 32'd0;
            disp_reg     <= 32'd0;
            op_reg       <= ffc_pkg::OP_NONE;
            fresh_reg    <= 1'b1;
            frozen_reg   <= 1'b0;
            accepted_reg <= 1'b0;
            cnt_reg      <= 5'd0;
        end
        else
        begin
            acc_reg      <= acc_next;
            disp_reg     <= disp_next;
            op_reg       <= op_next;
            fresh_reg    <= fresh_next;
            frozen_reg   <= frozen_next;
            accepted_reg <= accepted_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
            key_reg <= key_code;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        if (cmd.capture)
        begin
            out_value_reg    <= disp_reg;
            out_accepted_reg <= accepted_reg;
            out_fresh_reg    <= fresh_reg;
        end
    end

    assign shown_value  = $signed(out_value_reg);
    assign key_accepted = out_accepted_reg;
    assign shows_result = out_fresh_reg;

endmodule

`default_nettype wire

>>> src/four_function_calculator_keypad.sv
// A clear, digit, ignored key, or operator finishing none/add/sub/divide-by-zero goes
// from decode straight to the result register; finishing a multiply or divide first
// runs 32 passes of the shared shift-add / restoring-divide unit, then a finish step.
// Keys: the next key is taken only after the previous key's result has been captured.
// Reset (rst_n, asynchronous, active low): accumulator and display 0, no pending operator,
// fresh entry set, no result pending.
`default_nettype none

module four_function_calculator_keypad
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               key_valid,
    output logic                    key_stall,
    input  wire logic [7:0]         key_code,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      shown_value,
    output logic                    key_accepted,
    output logic                    shows_result
);

    ffc_pkg::ctrl_cmd_t  cmd;
    ffc_pkg::dp_status_t status;

    ffc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ffc_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_code     (key_code),
        .cmd          (cmd),
        .status       (status),
        .shown_value  (shown_value),
        .key_accepted (key_accepted),
        .shows_result (shows_result)
    );

endmodule

`default_nettype wire

>>> src/ffc_chk.sv
`default_nettype none

module ffc_chk
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               key_valid,
    input wire logic               key_stall,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire logic signed [31:0] shown_value,
    input wire logic               key_accepted,
    input wire logic               shows_result
);

    // one transaction in flight: busy straight after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key_stall) |=> key_stall)
        else $error("key channel not stalled after a transaction");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key_stall) |=> !$rose(res_valid))
        else $error("result appeared too soon after a transaction");

    // an entry in progress is never negative
    a_entry_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !shows_result) |-> !shown_value[31])
        else $error("negative value during digit entry");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> ($stable(shown_value) && $stable(key_accepted) &&
                                      $stable(shows_result)))
        else $error("result changed while stalled");

endmodule

bind four_function_calculator_keypad ffc_chk u_ffc_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .shown_value  (shown_value),
    .key_accepted (key_accepted),
    .shows_result (shows_result)
);

`default_nettype wire

>>> sim/four_function_calculator_keypad_test.sv
`timescale 1ns / 1ps

module four_function_calculator_keypad_test;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [31:0] ENTRY_LIMIT = ffc_pkg::ENTRY_MAX[31:0];

    typedef struct {
        logic signed [31:0] value;
        logic               accepted;
        logic               fresh;
    } reading_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               key_valid = 1'b0;
    logic               key_stall;
    logic [7:0]         key_code = 8'h00;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [31:0] shown_value;
    logic               key_accepted;
    logic               shows_result;

    four_function_calculator_keypad dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_code     (key_code),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .shown_value  (shown_value),
        .key_accepted (key_accepted),
        .shows_result (shows_result)
    );

    // calculator state as predicted
    logic [31:0]   calc_acc = '0;
    ffc_pkg::op_t  calc_op = ffc_pkg::OP_NONE;
    logic [31:0]   calc_disp = '0;
    logic          calc_fresh = 1'b1;
    logic          calc_frozen = 1'b0;

    reading_t readings_q[$];
    reading_t want_r;

    bit no_idle = 1'b0;
    int cycle_count = 0;
    int fail_count = 0;
    int keys_sent = 0;
    int keys_recognised = 0;
    int readings_checked = 0;
    int stall_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit predict_key(input logic [7:0] k);
        reading_t     r;
        logic [31:0]  operand;
        logic [31:0]  digit;
        ffc_pkg::op_t next_op;
        r.accepted = 1'b1;
        next_op = ffc_pkg::OP_NONE;
        case (k)
            ffc_pkg::KEY_ESC, ffc_pkg::KEY_LC_C, ffc_pkg::KEY_UC_C:
            begin
                calc_acc    = '0;
                calc_op     = ffc_pkg::OP_NONE;
                calc_disp   = '0;
                calc_fresh  = 1'b1;
                calc_frozen = 1'b0;
            end
            ffc_pkg::KEY_CR, ffc_pkg::KEY_LF, ffc_pkg::KEY_EQ, ffc_pkg::KEY_PLUS,
            ffc_pkg::KEY_MINUS, ffc_pkg::KEY_STAR, ffc_pkg::KEY_SLASH:
            begin
                operand = (calc_disp == ffc_pkg::INT_MIN_BITS) ? 32'd0 : calc_disp;
                case (calc_op)
                    ffc_pkg::OP_ADD: calc_acc = calc_acc + operand;
                    ffc_pkg::OP_SUB: calc_acc = calc_acc - operand;
                    ffc_pkg::OP_MUL: calc_acc = calc_acc * operand;
                    ffc_pkg::OP_DIV:
                    begin
                        if (operand != 32'd0)
                        begin
                            if (calc_acc == ffc_pkg::INT_MIN_BITS &&
                                operand == 32'hFFFF_FFFF)
                                calc_acc = ffc_pkg::INT_MIN_BITS;
                            else
                                calc_acc = $signed(calc_acc) / $signed(operand);
                        end
                    end
                    default: calc_acc = operand;
                endcase
                case (k)
                    ffc_pkg::KEY_PLUS:  next_op = ffc_pkg::OP_ADD;
                    ffc_pkg::KEY_MINUS: next_op = ffc_pkg::OP_SUB;
                    ffc_pkg::KEY_STAR:  next_op = ffc_pkg::OP_MUL;
                    ffc_pkg::KEY_SLASH: next_op = ffc_pkg::OP_DIV;
                    default:            next_op = ffc_pkg::OP_NONE;
                endcase
                calc_op     = next_op;
                calc_fresh  = 1'b1;
                calc_frozen = 1'b0;
                calc_disp   = calc_acc;
            end
            default:
            begin
                if (k >= ffc_pkg::KEY_D0 && k <= ffc_pkg::KEY_D9)
                begin
                    digit = 32'(k - ffc_pkg::KEY_D0);
                    if (calc_fresh)
                    begin
                        calc_disp   = digit;
                        calc_fresh  = 1'b0;
                        calc_frozen = 1'b0;
                    end
                    else if (!calc_frozen)
                    begin
                        if (calc_disp > (ENTRY_LIMIT - digit) / 32'd10)
                            calc_frozen = 1'b1;
                        else
                            calc_disp = calc_disp * 32'd10 + digit;
                    end
                end
                else
                    r.accepted = 1'b0;
            end
        endcase
        r.value = calc_disp;
        r.fresh = calc_fresh;
        readings_q.push_back(r);
        return r.accepted;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return ffc_pkg::KEY_PLUS;
            1: return ffc_pkg::KEY_MINUS;
            2: return ffc_pkg::KEY_STAR;
            default: return ffc_pkg::KEY_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 2))
            0: return ffc_pkg::KEY_EQ;
            1: return ffc_pkg::KEY_CR;
            default: return ffc_pkg::KEY_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_clear();
        case ($urandom_range(0, 2))
            0: return ffc_pkg::KEY_ESC;
            1: return ffc_pkg::KEY_LC_C;
            default: return ffc_pkg::KEY_UC_C;
        endcase
    endfunction

    // one key transaction; expectation is recorded at the accepting edge
    task automatic send_key(input logic [7:0] k);
        int gap;
        key_valid <= 1'b1;
        key_code  <= k;
        do
            @(posedge clk);
        while (key_stall);
        keys_sent++;
        if (predict_key(k))
            keys_recognised++;
        gap = pick_gap();
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_key(s[i]);
    endtask

    task automatic drain_results();
        key_valid <= 1'b0;
        while (readings_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_number();
        int r;
        int len;
        r = $urandom_range(0, 19);
        if (r == 19)
        begin
            // right at the entry limit
            send_text("214748364");
            send_key(ffc_pkg::KEY_D0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1)
                send_key(ffc_pkg::KEY_D0 + 8'($urandom_range(0, 9)));
        end
        else
        begin
            if (r < 12)
                len = $urandom_range(1, 3);
            else if (r < 17)
                len = $urandom_range(4, 9);
            else
                len = $urandom_range(10, 12);
            repeat (len) send_key(ffc_pkg::KEY_D0 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_chain();
        int r;
        int terms;
        if ($urandom_range(0, 3) != 0)
            send_number();
        terms = $urandom_range(0, 4);
        repeat (terms)
        begin
            send_key(pick_operator());
            if ($urandom_range(0, 7) == 0)
                send_key(pick_operator());
            send_number();
        end
        r = $urandom_range(0, 9);
        if (r < 7)
            send_key(pick_terminator());
        else if (r < 9)
            send_key(pick_clear());
    endtask

    task automatic test_directed_keys();
        no_idle = 1'b0;
        send_key(8'h00);
        send_key(8'hFF);
        // largest entry, frozen digit, wrap to the most negative value
        send_text("21474836479+1");
        send_key(ffc_pkg::KEY_CR);
        // most negative value taken as zero
        send_key(ffc_pkg::KEY_STAR);
        // truncation toward zero, then division by zero
        send_key(ffc_pkg::KEY_ESC);
        send_text("07-16/5/0=");
        send_key(ffc_pkg::KEY_UC_C);
        drain_results();
    endtask

    task automatic test_well_formed_chains();
        int  base;
        bit  paused;
        base = keys_recognised;
        paused = 1'b0;
        no_idle = 1'b0;
        while (keys_recognised - base < 850)
        begin
            send_chain();
            if (!paused && keys_recognised - base >= 425)
            begin
                drain_results();
                repeat (20) @(posedge clk);
                paused = 1'b1;
            end
        end
        drain_results();
    endtask

    task automatic test_noise_keys();
        int base;
        int r;
        base = keys_sent;
        no_idle = 1'b0;
        while (keys_sent - base < 250)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_key(8'($urandom_range(0, 255)));
            else if (r < 6)
                send_key(ffc_pkg::KEY_D0 + 8'($urandom_range(0, 9)));
            else if (r < 8)
                send_key(pick_operator());
            else if (r < 9)
                send_key(pick_terminator());
            else
                send_key(pick_clear());
        end
        drain_results();
    endtask

    task automatic test_back_to_back();
        int base;
        base = keys_recognised;
        no_idle = 1'b1;
        while (keys_recognised - base < 250)
            send_chain();
        drain_results();
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (readings_q.size() == 0)
            begin
                $error("unexpected result: shown_value %0d", shown_value);
                fail_count++;
            end
            else
            begin
                want_r = readings_q.pop_front();
                readings_checked++;
                if (shown_value !== want_r.value)
                begin
                    $error("shown_value: expected %0d, got %0d", want_r.value, shown_value);
                    fail_count++;
                end
                if (key_accepted !== want_r.accepted)
                begin
                    $error("key_accepted: expected %0b, got %0b", want_r.accepted,
                           key_accepted);
                    fail_count++;
                end
                if (shows_result !== want_r.fresh)
                begin
                    $error("shows_result: expected %0b, got %0b", want_r.fresh, shows_result);
                    fail_count++;
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall  <= 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
            res_stall  <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_well_formed_chains();
        test_noise_keys();
        test_back_to_back();
        drain_results();
        repeat (80) @(posedge clk);
        if (readings_q.size() != 0)
        begin
            $error("%0d results never arrived", readings_q.size());
            fail_count++;
        end
        $display("Sent %0d keys (%0d recognised): chains, noise and back-to-back bursts",
                 keys_sent, keys_recognised);
        $display("Checked %0d results in %0d cycles", readings_checked, cycle_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> four_function_calculator_keypad.f
src/ffc_pkg.sv
src/ffc_ctrl.sv
src/ffc_dp.sv
src/four_function_calculator_keypad.sv
src/ffc_chk.sv
sim/four_function_calculator_keypad_test.sv
